// ===== src/prs_pkg.sv =====
package prs_pkg;

    localparam int unsigned NUM_ROUNDS = 31;
    localparam int unsigned LATENCY    = NUM_ROUNDS + 1;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

    typedef struct packed {
        logic        valid;
        logic [63:0] state;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } t_stage;

    localparam logic [3:0] SBOX [16] = '{
        4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
        4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    function automatic logic [63:0] sub_layer(input logic [63:0] v);
        logic [63:0] o;
        o = '0;
        for (int n = 0; n < 16; n++) begin
            o[4*n +: 4] = SBOX[v[4*n +: 4]];
        end
        return o;
    endfunction

    function automatic logic [63:0] perm_layer(input logic [63:0] v);
        logic [63:0] o;
        o = '0;
        for (int j = 0; j < 64; j++) begin
            o[16*(j % 4) + j / 4] = v[j];
        end
        return o;
    endfunction

    function automatic logic [127:0] key_update(input logic [127:0] k,
                                                input logic [4:0]   round);
        logic [127:0] nk;
        nk = {k[66:0], k[127:67]};
        nk[127:124] = SBOX[nk[127:124]];
        nk[123:120] = SBOX[nk[123:120]];
        nk[66:62]   = nk[66:62] ^ round;
        return nk;
    endfunction

endpackage

// ===== src/present128_block_encrypt.sv =====
// PRESENT-128 encryption engine. A plaintext word is taken at every clock edge where start
// is high; busy is never raised, so a new word may follow in every cycle. Each word passes
// through a chain of 31 round cells, one round per cell and cycle, with its own copy of the
// key schedule, and then an output register that adds the last round key. The ciphertext
// and o_done are held for one cycle, driven from the output register; the receiver cannot
// stall it. The key must be written by the user through the configuration channel while
// no word is in flight (not enforced). Each word uses the key held when it was taken.
module present128_block_encrypt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [63:0]                   i_plaintext,
    output logic                          o_done,
    output logic [63:0]                   o_ciphertext,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    logic [63:0]     r_key_high;
    logic [63:0]     r_key_low;
    logic            r_done;
    logic [63:0]     r_ciphertext;
    prs_pkg::t_stage w_chain [prs_pkg::NUM_ROUNDS+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                prs_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                prs_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_chain[0].valid  = start && !busy;
    assign w_chain[0].state  = i_plaintext;
    assign w_chain[0].key_hi = r_key_high;
    assign w_chain[0].key_lo = r_key_low;

    for (genvar g = 0; g < prs_pkg::NUM_ROUNDS; g++) begin : g_round
        prs_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (5'(g + 1)),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_chain[prs_pkg::NUM_ROUNDS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ciphertext <= w_chain[prs_pkg::NUM_ROUNDS].state
                        ^ w_chain[prs_pkg::NUM_ROUNDS].key_hi;
    end

    assign o_done       = r_done;
    assign o_ciphertext = r_ciphertext;

    a_word_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(prs_pkg::LATENCY) o_done)
        else $error("accepted word did not complete on time");

    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, prs_pkg::LATENCY))
        else $error("result strobe without an accepted word");

    a_chain_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[prs_pkg::NUM_ROUNDS].valid |=> o_done)
        else $error("last round cell output was not delivered");

endmodule

// ===== src/prs_round_cell.sv =====
module prs_round_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [4:0]       i_round,
    input  prs_pkg::t_stage  i_stage,
    output prs_pkg::t_stage  o_stage
);

    logic         r_valid;
    logic [63:0]  r_state;
    logic [127:0] r_key;
    logic [63:0]  n_state;
    logic [127:0] n_key;

    always_comb begin
        n_state = prs_pkg::perm_layer(prs_pkg::sub_layer(i_stage.state ^ i_stage.key_hi));
        n_key   = prs_pkg::key_update({i_stage.key_hi, i_stage.key_lo}, i_round);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_key   <= n_key;
    end

    assign o_stage.valid  = r_valid;
    assign o_stage.state  = r_state;
    assign o_stage.key_hi = r_key[127:64];
    assign o_stage.key_lo = r_key[63:0];

endmodule

// ===== dv/tb_present128_block_encrypt.sv =====
module tb_present128_block_encrypt;

    localparam logic [prs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [prs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [63:0]          ALL_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam int                   RANDOM_WORDS = 1032;
    localparam int                   DRAIN_CYCLES = prs_pkg::LATENCY + 8;

    localparam logic [3:0] PRESENT_SBOX [16] = '{
        4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
        4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    typedef enum logic [1:0] {JOB_WORD, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind                     kind;
        logic [prs_pkg::CFG_IDX_W-1:0] idx;
        logic [63:0]                   data;
    } t_job;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [63:0]                   i_plaintext  = '0;
    logic                          o_done;
    logic [63:0]                   o_ciphertext;
    logic                          i_cfg_valid  = 1'b0;
    logic                          o_cfg_ready;
    logic [prs_pkg::CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [63:0]                   i_cfg_data   = '0;

    t_job        block_jobs[$];
    logic [63:0] ciphertext_due[$];
    logic [63:0] key_hi_shadow = '0;
    logic [63:0] key_lo_shadow = '0;
    int          words_sent    = 0;
    int          words_done    = 0;
    int          key_writes    = 0;
    int          spare_writes  = 0;
    int          mismatches    = 0;
    int          burst_left    = 1;
    int          gap_left      = 0;

    present128_block_encrypt dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_plaintext  (i_plaintext),
        .o_done       (o_done),
        .o_ciphertext (o_ciphertext),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] present_encrypt(input logic [63:0] block,
                                                    input logic [63:0] kh,
                                                    input logic [63:0] kl);
        logic [127:0] key;
        logic [63:0]  st;
        logic [63:0]  sb;
        key = {kh, kl};
        st  = block;
        for (int r = 1; r <= prs_pkg::NUM_ROUNDS; r++) begin
            st = st ^ key[127:64];
            for (int n = 0; n < 16; n++) begin
                sb[4*n +: 4] = PRESENT_SBOX[st[4*n +: 4]];
            end
            for (int j = 0; j < 64; j++) begin
                st[16*(j % 4) + j / 4] = sb[j];
            end
            key = (key << 61) | (key >> 67);
            key[127:124] = PRESENT_SBOX[key[127:124]];
            key[123:120] = PRESENT_SBOX[key[123:120]];
            key[66:62]   = key[66:62] ^ 5'(r);
        end
        return st ^ key[127:64];
    endfunction

    function automatic void add_word(input logic [63:0] data);
        block_jobs.push_back('{kind: JOB_WORD, idx: '0, data: data});
    endfunction

    function automatic void add_key_write(input logic [prs_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [63:0] data);
        block_jobs.push_back('{kind: JOB_CFG, idx: idx, data: data});
    endfunction

    function automatic logic [63:0] pick_key_half();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_plaintext();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin : driver
        t_job job;
        logic nxt_start;
        logic nxt_cfg;
        nxt_start = start;
        nxt_cfg   = i_cfg_valid;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            nxt_cfg   = 1'b0;
        end else begin
            if (start && !busy) begin
                ciphertext_due.push_back(present_encrypt(i_plaintext, key_hi_shadow,
                                                         key_lo_shadow));
                words_sent++;
                nxt_start = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 8);
                    gap_left   = $urandom_range(0, ($urandom_range(0, 5) == 0) ? 24 : 5);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    prs_pkg::CFG_KEY_HIGH: key_hi_shadow = i_cfg_data;
                    prs_pkg::CFG_KEY_LOW:  key_lo_shadow = i_cfg_data;
                    default:               spare_writes++;
                endcase
                key_writes++;
                nxt_cfg = 1'b0;
            end
            if (!nxt_start && !nxt_cfg && block_jobs.size() > 0) begin
                job = block_jobs[0];
                case (job.kind)
                    JOB_WORD: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            void'(block_jobs.pop_front());
                            i_plaintext <= job.data;
                            nxt_start = 1'b1;
                        end
                    end
                    JOB_CFG: begin
                        if (words_sent == words_done) begin
                            void'(block_jobs.pop_front());
                            i_cfg_index <= job.idx;
                            i_cfg_data  <= job.data;
                            nxt_cfg = 1'b1;
                        end
                    end
                    default: begin
                        if (words_sent == words_done) void'(block_jobs.pop_front());
                    end
                endcase
            end
        end
        start       <= nxt_start;
        i_cfg_valid <= nxt_cfg;
    end

    always @(posedge i_clk) begin : monitor
        logic [63:0] want;
        if (i_rst_n && o_done) begin
            if (ciphertext_due.size() == 0) begin
                $error("ciphertext: no word expected, actual %h", o_ciphertext);
                mismatches++;
            end else begin
                want = ciphertext_due.pop_front();
                if (o_ciphertext !== want) begin
                    $error("ciphertext: expected %h, actual %h", want, o_ciphertext);
                    mismatches++;
                end
            end
            words_done <= words_done + 1;
        end
    end

    initial begin : stimulus
        int remaining;
        int phase_len;

        // Reset key of all zeros first, then a series of fixed keys.
        add_word('0);
        add_word(ALL_ONES);
        add_word(64'd1);
        add_word(64'h8000_0000_0000_0000);
        add_key_write(prs_pkg::CFG_KEY_HIGH, ALL_ONES);
        add_key_write(prs_pkg::CFG_KEY_LOW, ALL_ONES);
        add_word('0);
        add_word(ALL_ONES);
        add_word(64'haaaa_aaaa_aaaa_aaaa);
        add_word(64'h5555_5555_5555_5555);
        add_key_write(prs_pkg::CFG_KEY_HIGH, '0);
        add_word('0);
        add_word(ALL_ONES);
        add_key_write(prs_pkg::CFG_KEY_LOW, '0);
        add_key_write(prs_pkg::CFG_KEY_HIGH, ALL_ONES);
        add_word('0);
        add_word(ALL_ONES);
        // Writes to unused indexes must leave the key untouched.
        add_key_write(CFG_SPARE_A, {$urandom, $urandom});
        add_key_write(CFG_SPARE_B, {$urandom, $urandom});
        add_word('0);
        add_word(ALL_ONES);
        add_key_write(prs_pkg::CFG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
        add_key_write(prs_pkg::CFG_KEY_LOW, 64'hfedc_ba98_7654_3210);
        add_word(64'h0123_4567_89ab_cdef);
        add_word(64'hfedc_ba98_7654_3210);
        add_word(64'h0f0f_0f0f_0f0f_0f0f);
        add_word(64'hf0f0_f0f0_f0f0_f0f0);

        remaining = RANDOM_WORDS;
        while (remaining > 0) begin
            if ($urandom_range(0, 1) == 0) begin
                add_key_write(prs_pkg::CFG_KEY_HIGH, pick_key_half());
                if ($urandom_range(0, 3) != 0) begin
                    add_key_write(prs_pkg::CFG_KEY_LOW, pick_key_half());
                end
            end else begin
                add_key_write(prs_pkg::CFG_KEY_LOW, pick_key_half());
                if ($urandom_range(0, 3) != 0) begin
                    add_key_write(prs_pkg::CFG_KEY_HIGH, pick_key_half());
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                add_key_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                              {$urandom, $urandom});
            end
            phase_len = $urandom_range(40, 150);
            if (phase_len > remaining) phase_len = remaining;
            for (int k = 0; k < phase_len; k++) begin
                add_word(pick_plaintext());
                if ($urandom_range(0, 99) == 0) begin
                    block_jobs.push_back('{kind: JOB_DRAIN, idx: '0, data: '0});
                end
            end
            remaining -= phase_len;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (block_jobs.size() > 0 || start || i_cfg_valid) @(negedge i_clk);
        while (words_sent != words_done) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (ciphertext_due.size() != 0) begin
            $error("ciphertext: %0d expected words never arrived", ciphertext_due.size());
            mismatches++;
        end
        $display("Encrypted %0d blocks; %0d ciphertext words checked.", words_sent,
                 words_done);
        $display("Key register writes: %0d, of which %0d went to unused indexes.",
                 key_writes, spare_writes);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
